FILE: sv/aors_pkg.sv
// Shared types, constants and guard-bit helper for the accumulator round/saturate unit.
`default_nettype none

package aors_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned CSR_W  = 2;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_LEFT2 = 2'd1;
   localparam logic [1:0] MODE_LEFT4 = 2'd2;
   localparam logic [1:0] MODE_RIGHT8 = 2'd3;

   localparam logic CSR_SHIFT_MODE = 1'b0;
   localparam logic CSR_SATURATE   = 1'b1;

   localparam logic [WORD_W-1:0] GUARD_M0   = 64'h000f_8000_0000_0000;
   localparam logic [WORD_W-1:0] GUARD_M1   = 64'h000f_e000_0000_0000;
   localparam logic [WORD_W-1:0] GUARD_M2   = 64'h000f_f800_0000_0000;
   localparam logic [WORD_W-1:0] SIGN_BIT51 = 64'h0008_0000_0000_0000;
   localparam logic [WORD_W-1:0] NEG_LIMIT  = 64'hffff_8000_0000_0000;
   localparam logic [WORD_W-1:0] POS_LIMIT  = 64'h0000_7fff_ffff_ffff;

   typedef struct packed {
      logic [1:0] shift_mode;
      logic       saturate_enable;
   } cfg_type;

   function automatic logic guard_bad(input logic [WORD_W-1:0] v,
                                      input logic [WORD_W-1:0] mask);
      logic [WORD_W-1:0] g;
      g = v & mask;
      return (g != '0) && (g != mask);
   endfunction

endpackage

`default_nettype wire

FILE: sv/aors_pipe.sv
// Three-stage shift, round, mask and saturate pipeline with per-stage valid and stall.
`default_nettype none

module aors_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire aors_pkg::cfg_type             cfg,
   input  wire logic                          in_valid,
   output logic                               in_stall,
   input  wire logic                          in_type,
   input  wire logic [aors_pkg::WORD_W-1:0]   in_value,
   input  wire logic [aors_pkg::WORD_W-1:0]   in_round,
   input  wire logic [aors_pkg::WORD_W-1:0]   in_mask,
   output logic                               out_valid,
   input  wire logic                          out_stall,
   output logic [aors_pkg::WORD_W-1:0]        out_result,
   output logic                               out_overflow
);

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_conv_ff, s1_conv_in;
   logic                          s1_over_ff, s1_over_in;
   logic [aors_pkg::WORD_W-1:0]   s1_value_ff, s1_value_in;
   logic [aors_pkg::WORD_W-1:0]   s1_round_ff;
   logic [aors_pkg::WORD_W-1:0]   s1_mask_ff;

   logic                          s2_valid_ff;
   logic                          s2_conv_ff;
   logic                          s2_over_ff;
   logic [aors_pkg::WORD_W-1:0]   s2_value_ff, s2_value_in;

   logic                          s3_valid_ff;
   logic                          s3_over_ff, s3_over_in;
   logic [aors_pkg::WORD_W-1:0]   s3_value_ff, s3_value_in;

   logic adv1, adv2, adv3;

   assign adv3 = !s3_valid_ff || !out_stall;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_stall = !adv1;
   assign s1_valid_in = in_valid;

   // stage 1: first guard check and scaling
   always_comb begin
      s1_conv_in  = !in_type;
      s1_over_in  = 1'b0;
      s1_value_in = in_value;
      case (cfg.shift_mode)
         aors_pkg::MODE_NONE: begin
            s1_over_in = aors_pkg::guard_bad(in_value, aors_pkg::GUARD_M0);
         end
         aors_pkg::MODE_LEFT2: begin
            s1_over_in = aors_pkg::guard_bad(in_value, aors_pkg::GUARD_M1);
            if (s1_conv_in) s1_value_in = {in_value[aors_pkg::WORD_W-3:0], 2'b00};
         end
         aors_pkg::MODE_LEFT4: begin
            s1_over_in = aors_pkg::guard_bad(in_value, aors_pkg::GUARD_M2);
            if (s1_conv_in) s1_value_in = {in_value[aors_pkg::WORD_W-5:0], 4'b0000};
         end
         aors_pkg::MODE_RIGHT8: begin
            if (s1_conv_in) begin
               s1_value_in = {{8{in_value[aors_pkg::WORD_W-1]}},
                              in_value[aors_pkg::WORD_W-1:8]};
            end
         end
         default: begin
            s1_over_in = 1'b0;
         end
      endcase
   end

   // stage 2: round and mask
   assign s2_value_in = s1_conv_ff ? ((s1_value_ff + s1_round_ff) & s1_mask_ff) : s1_value_ff;

   // stage 3: second guard check and saturation
   always_comb begin
      s3_over_in = s2_over_ff ||
                   (s2_conv_ff && aors_pkg::guard_bad(s2_value_ff, aors_pkg::GUARD_M0));
      s3_value_in = s2_value_ff;
      if (s3_over_in && cfg.saturate_enable) begin
         s3_value_in = ((s2_value_ff & aors_pkg::SIGN_BIT51) != '0) ?
                       aors_pkg::NEG_LIMIT : aors_pkg::POS_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= s1_valid_in;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         s1_conv_ff  <= s1_conv_in;
         s1_over_ff  <= s1_over_in;
         s1_value_ff <= s1_value_in;
         s1_round_ff <= in_round;
         s1_mask_ff  <= in_mask;
      end
      if (adv2 && s1_valid_ff) begin
         s2_conv_ff  <= s1_conv_ff;
         s2_over_ff  <= s1_over_ff;
         s2_value_ff <= s2_value_in;
      end
      if (adv3 && s2_valid_ff) begin
         s3_over_ff  <= s3_over_in;
         s3_value_ff <= s3_value_in;
      end
   end

   assign out_valid    = s3_valid_ff;
   assign out_result   = s3_value_ff;
   assign out_overflow = s3_over_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv2) |=> s1_valid_ff)
      else $error("stage 1 word dropped while stage 2 was blocked");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_over_ff && cfg.saturate_enable) |->
      (s3_value_ff == aors_pkg::NEG_LIMIT || s3_value_ff == aors_pkg::POS_LIMIT))
      else $error("overflowed word not saturated to a limit");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff) |-> !in_stall)
      else $error("empty pipeline stalls input");

endmodule

`default_nettype wire

FILE: sv/accumulator_output_round_saturate_unit.sv
// Top level of the accumulator output round/saturate unit: control registers and pipeline.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | req_type, macc_value, round_add, result_mask
//   rsp     | out       | rsp_valid/stall   | rsp_result, rsp_overflow
//   csr     | in        | csr_write         | csr_index, csr_data
//
// One word per cycle sustained while rsp is not stalled; an accepted word passes through
// three registered stages (shift and first guard check, 64-bit rounding add and mask, second
// check and saturate), and rsp_valid rises when it is held in the third stage register.
// Reset clears the valid bits and sets shift_mode and saturate_enable to zero.
// A stalled rsp word holds; each stage fills its bubble, so req_stall rises only when
// all three stages are occupied and rsp is stalled.
`default_nettype none

module accumulator_output_round_saturate_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [aors_pkg::CSR_W-1:0]    csr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_type,
   input  wire logic [aors_pkg::WORD_W-1:0]   req_macc_value,
   input  wire logic [aors_pkg::WORD_W-1:0]   req_round_add,
   input  wire logic [aors_pkg::WORD_W-1:0]   req_result_mask,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [aors_pkg::WORD_W-1:0]        rsp_result,
   output logic                               rsp_overflow
);

   aors_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            aors_pkg::CSR_SHIFT_MODE: cfg_ff.shift_mode      <= csr_data;
            aors_pkg::CSR_SATURATE:   cfg_ff.saturate_enable <= csr_data[0];
            default:                  cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   aors_pipe u_pipe (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_type      (req_type),
      .in_value     (req_macc_value),
      .in_round     (req_round_add),
      .in_mask      (req_result_mask),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_result   (rsp_result),
      .out_overflow (rsp_overflow)
   );

endmodule

`default_nettype wire
